// File: hw/rtl/sefd_pkg.sv
// ----------------------------------------------------------------------------
// sefd_pkg
// Shared types and byte codes for the stx/etx escaped frame decoder.
// ----------------------------------------------------------------------------
package sefd_pkg;

  localparam logic [7:0] STX_BYTE   = 8'h02;
  localparam logic [7:0] ETX_BYTE   = 8'h03;
  localparam logic [7:0] ESC_BYTE   = 8'h7D;
  localparam logic [7:0] ESC_XOR    = 8'h20;
  localparam logic [3:0] FULL_COUNT = 4'd8;
  localparam int         FIELD_BYTES = 6;
  localparam logic [3:0] FIELD_FIRST = 4'd2;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       chunk_end;
  } sefd_in_t;

  typedef struct packed {
    logic [15:0]        tab_id;
    logic signed [31:0] encoder_count;
    logic               frame_short;
  } sefd_out_t;

  // decoder status seen by the top level
  typedef struct packed {
    logic       in_frame;
    logic       escape_pending;
    logic [3:0] decoded_index;
  } sefd_status_t;

endpackage

// File: hw/rtl/sefd_in_stage.sv
// ----------------------------------------------------------------------------
// sefd_in_stage
// Input register: holds one accepted byte request until the decoder steps it.
// ----------------------------------------------------------------------------
module sefd_in_stage (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  sefd_pkg::sefd_in_t in_data,
  input  logic              advance,
  output logic              s1_valid,
  output sefd_pkg::sefd_in_t s1_data
);
  import sefd_pkg::*;

  logic     valid_r;
  logic     valid_nxt;
  sefd_in_t data_r;

  assign in_ready  = !valid_r || advance;
  assign valid_nxt = in_ready ? in_valid : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      data_r <= in_data;
    end
  end

  assign s1_valid = valid_r;
  assign s1_data  = data_r;

endmodule

// File: hw/rtl/sefd_decode.sv
// ----------------------------------------------------------------------------
// sefd_decode
// Frame state and single-pass byte decode; produces at most one result a step.
// ----------------------------------------------------------------------------
module sefd_decode (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  step,
  input  sefd_pkg::sefd_in_t    s1_data,
  output logic                  res_valid,
  output sefd_pkg::sefd_out_t   res_data,
  output sefd_pkg::sefd_status_t status
);
  import sefd_pkg::*;

  logic        in_frame_r, in_frame_nxt;
  logic        esc_r, esc_nxt;
  logic [3:0]  idx_r, idx_nxt;
  logic [47:0] fb_r, fb_nxt;

  logic        put_en;
  logic [7:0]  put_val;
  logic [3:0]  idx_put;
  logic [47:0] fb_put;
  logic [7:0]  b;

  assign b = s1_data.rx_byte;

  // which decoded byte, if any, this request appends, and whether it yields a result
  always_comb begin
    put_en    = 1'b0;
    put_val   = b;
    res_valid = 1'b0;
    if (b != STX_BYTE && in_frame_r) begin
      if (b == ETX_BYTE) begin
        put_en    = esc_r;
        put_val   = ETX_BYTE ^ ESC_XOR;
        res_valid = 1'b1;
      end else if (esc_r) begin
        put_en  = 1'b1;
        put_val = b ^ ESC_XOR;
      end else if (b != ESC_BYTE) begin
        put_en = 1'b1;
      end
    end
  end

  always_comb begin
    fb_put  = fb_r;
    idx_put = idx_r;
    if (put_en) begin
      for (int k = 0; k < FIELD_BYTES; k++) begin
        if (idx_r == FIELD_FIRST + 4'(k)) begin
          fb_put[k*8 +: 8] = put_val;
        end
      end
      if (idx_r < FULL_COUNT) begin
        idx_put = idx_r + 4'd1;
      end
    end
  end

  always_comb begin
    in_frame_nxt = in_frame_r;
    esc_nxt      = esc_r;
    idx_nxt      = idx_put;
    fb_nxt       = fb_put;
    if (b == STX_BYTE) begin
      in_frame_nxt = 1'b1;
      esc_nxt      = 1'b0;
      idx_nxt      = 4'd1;
      fb_nxt       = '0;
    end else if (in_frame_r) begin
      if (b == ETX_BYTE) begin
        in_frame_nxt = 1'b0;
        esc_nxt      = 1'b0;
      end else if (esc_r) begin
        esc_nxt = 1'b0;
      end else if (b == ESC_BYTE) begin
        esc_nxt = 1'b1;
      end
    end
    if (s1_data.chunk_end) begin
      in_frame_nxt = 1'b0;
      esc_nxt      = 1'b0;
      idx_nxt      = 4'd0;
    end
  end

  assign res_data.tab_id        = fb_put[15:0];
  assign res_data.encoder_count = $signed(fb_put[47:16]);
  assign res_data.frame_short   = (idx_put < FULL_COUNT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_frame_r <= 1'b0;
      esc_r      <= 1'b0;
      idx_r      <= 4'd0;
      fb_r       <= '0;
    end else if (step) begin
      in_frame_r <= in_frame_nxt;
      esc_r      <= esc_nxt;
      idx_r      <= idx_nxt;
      fb_r       <= fb_nxt;
    end
  end

  assign status.in_frame       = in_frame_r;
  assign status.escape_pending = esc_r;
  assign status.decoded_index  = idx_r;

endmodule

// File: hw/rtl/sefd_out_stage.sv
// ----------------------------------------------------------------------------
// sefd_out_stage
// Result register: holds one decoded frame request until it is taken.
// ----------------------------------------------------------------------------
module sefd_out_stage (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               load,
  input  sefd_pkg::sefd_out_t res_data,
  output logic               can_load,
  output logic               out_valid,
  input  logic               out_ready,
  output sefd_pkg::sefd_out_t out_data
);
  import sefd_pkg::*;

  logic      valid_r;
  logic      valid_nxt;
  sefd_out_t data_r;

  assign can_load  = !valid_r || out_ready;
  assign valid_nxt = load ? 1'b1 : (valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= res_data;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

// File: hw/rtl/stx_etx_escaped_frame_decoder_top.sv
// ----------------------------------------------------------------------------
// stx_etx_escaped_frame_decoder_top
// Byte-stuffed stx/etx frame decoder: one raw byte per request in, one
// tab id / encoder count result per end byte of an open frame out.
// ----------------------------------------------------------------------------
// path: an accepted byte waits in the input register and, once it steps, its
//   result is loaded into the result register, which drives out_valid
// throughput: one byte per cycle while the result register can load, set by
//   the single decode step between the input register and the result register
// reset: synchronous rst_n clears both stage valids and the frame state
// ----------------------------------------------------------------------------
module stx_etx_escaped_frame_decoder_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  sefd_pkg::sefd_in_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output sefd_pkg::sefd_out_t out_data
);
  import sefd_pkg::*;

  logic         s1_valid;
  sefd_in_t     s1_data;
  logic         can_load;
  logic         advance;
  logic         res_valid;
  sefd_out_t    res_data;
  sefd_status_t status;

  // the held byte steps the decoder when the result register has room;
  // bytes that produce no result also wait, which keeps ordering simple
  assign advance = s1_valid && can_load;

  // input register, takes a new byte when empty or while the held one steps
  sefd_in_stage u_in (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .advance  (advance),
    .s1_valid (s1_valid),
    .s1_data  (s1_data)
  );

  // frame state and decode logic
  sefd_decode u_dec (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (advance),
    .s1_data   (s1_data),
    .res_valid (res_valid),
    .res_data  (res_data),
    .status    (status)
  );

  // result register, parts the decode path from the downstream ready
  sefd_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (advance && res_valid),
    .res_data  (res_data),
    .can_load  (can_load),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

`ifndef SYNTHESIS
  // decoded position saturates at eight
  a_idx_sat: assert property (@(posedge clk) disable iff (!rst_n)
    status.decoded_index <= FULL_COUNT)
    else $error("decoded index above saturation");

  // an escape can only be pending inside a frame
  a_esc_frame: assert property (@(posedge clk) disable iff (!rst_n)
    status.escape_pending |-> status.in_frame)
    else $error("escape pending outside a frame");

  // a result only comes out of an open frame
  a_res_frame: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |-> status.in_frame)
    else $error("result without an open frame");

  // a stepped chunk end always leaves the decoder idle
  a_chunk_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && s1_data.chunk_end) |=> (!status.in_frame && status.decoded_index == 4'd0))
    else $error("frame survived a chunk end");
`endif

endmodule
